@@ hw/rtl/hsv_saturation_scaler_defines.svh @@
// ----------------------------------------------------------------------------
// HSV saturation scaler assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HSV_SATURATION_SCALER_DEFINES_SVH
`define HSV_SATURATION_SCALER_DEFINES_SVH

// same-cycle implication
`define HSS_AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSS_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hss_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV saturation scaler package
// Fixed-point widths, reciprocal constants, payload types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_W     = FRAC_BITS + 1;
  localparam int NW        = 17;
  localparam int DIVW      = NW + FRAC_BITS;
  localparam int HW        = FRAC_BITS + 9;
  localparam int PW        = ONE_W + 8;
  localparam int TW        = FRAC_BITS + 6;
  localparam int XW        = FRAC_BITS + 8;

  localparam int K255  = XW + 8;
  localparam int M255W = K255 - 7;
  localparam logic [63:0] M255_64 = ((64'd1 << K255) + 64'd254) / 64'd255;
  localparam logic [M255W-1:0] M255 = M255W'(M255_64);

  localparam int K100  = PW + 7;
  localparam int M100W = K100 - 6;
  localparam logic [63:0] M100_64 = ((64'd1 << K100) + 64'd99) / 64'd100;
  localparam logic [M100W-1:0] M100 = M100W'(M100_64);

  localparam int K60  = TW + 6;
  localparam int M60W = K60 - 5;
  localparam logic [63:0] M60_64 = ((64'd1 << K60) + 64'd59) / 64'd60;
  localparam logic [M60W-1:0] M60 = M60W'(M60_64);

  localparam logic [ONE_W-1:0] ONE_Q   = ONE_W'(1) << FRAC_BITS;
  localparam logic [TW-1:0]    SIXTY_Q = TW'(60) << FRAC_BITS;
  localparam logic [ONE_W-1:0] S_MIN   = ONE_W'((64'd2 << FRAC_BITS) / 64'd1000);

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } hss_pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } hss_pix_out_t;

  typedef struct packed {
    logic [7:0]       mx;
    logic [7:0]       delta;
    logic [NW-1:0]    n;
    logic [ONE_W-1:0] v;
  } hss_work_t;

  typedef struct packed {
    logic      valid;
    hss_work_t work;
  } hss_qbus_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic [7:0] dvs,
                                          input logic dbit);
    logic [8:0] t;
    t = {rem, dbit};
    if (t >= {1'b0, dvs}) begin
      div_step = {1'b1, 8'(t - {1'b0, dvs})};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

  // Q1.F level to 8-bit channel, saturated
  function automatic logic [7:0] to_chan(input logic [ONE_W-1:0] y);
    logic [ONE_W+7:0] w;
    logic [8:0]       q;
    w = {y, 8'd0} - (ONE_W+8)'(y);
    q = 9'(w >> FRAC_BITS);
    to_chan = (q > 9'd255) ? 8'd255 : q[7:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hss_front.sv @@
// ----------------------------------------------------------------------------
// HSV saturation scaler front end
// Accepts pixels, finds max and delta, forms the hue numerator and value.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  hss_pkg::hss_pix_in_t in_pixel,
  output hss_pkg::hss_qbus_t  push
);
  import hss_pkg::*;

  logic [7:0]    r, g, b, mx, mn, delta;
  logic [NW-1:0] n;

  logic          f1_vld_r;
  logic [7:0]    f1_mx_r, f1_delta_r;
  logic [NW-1:0] f1_n_r;

  logic                 f2_vld_r;
  hss_work_t            f2_work_r;
  logic [XW-1:0]        vx;
  logic [XW+M255W-1:0]  vprod;

  assign r = in_pixel.in_red;
  assign g = in_pixel.in_green;
  assign b = in_pixel.in_blue;

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    if (r == mx) begin
      n = (g >= b) ? NW'(60) * NW'(8'(g - b))
                   : NW'(360) * NW'(delta) - NW'(60) * NW'(8'(b - g));
    end else if (g == mx) begin
      n = (b >= r) ? NW'(120) * NW'(delta) + NW'(60) * NW'(8'(b - r))
                   : NW'(120) * NW'(delta) - NW'(60) * NW'(8'(r - b));
    end else begin
      n = (r >= g) ? NW'(240) * NW'(delta) + NW'(60) * NW'(8'(r - g))
                   : NW'(240) * NW'(delta) - NW'(60) * NW'(8'(g - r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= in_acc;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_mx_r    <= mx;
    f1_delta_r <= delta;
    f1_n_r     <= n;
  end

  // v = ceil(mx * ONE / 255)
  assign vx    = {f1_mx_r, {FRAC_BITS{1'b0}}} + XW'(254);
  assign vprod = (XW+M255W)'(vx) * (XW+M255W)'(M255);

  always_ff @(posedge clk) begin
    f2_work_r.mx    <= f1_mx_r;
    f2_work_r.delta <= f1_delta_r;
    f2_work_r.n     <= f1_n_r;
    f2_work_r.v     <= ONE_W'(vprod >> K255);
  end

  assign push = {f2_vld_r, f2_work_r};

endmodule

`default_nettype wire

@@ hw/rtl/hss_queue.sv @@
// ----------------------------------------------------------------------------
// HSV saturation scaler work queue
// Short FIFO between front and back; raises busy early enough for in-flight work.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsv_saturation_scaler_defines.svh"

module hss_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  hss_pkg::hss_qbus_t push,
  output hss_pkg::hss_qbus_t pop,
  output logic               busy
);
  import hss_pkg::*;

  hss_work_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign pop  = {(cnt_r != '0), mem_r[rd_ptr_r]};
  assign busy = (cnt_r >= QCW'(QDEPTH - 2));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop.valid) cnt_nxt = cnt_r + QCW'(1);
    if (!push.valid && pop.valid) cnt_nxt = cnt_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop.valid) rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.work;
  end

  `HSS_AST_IMPL(a_q_no_overflow, push.valid, cnt_r != QCW'(QDEPTH), "queue overflow")
  `HSS_AST_NEXT(a_q_drain, !push.valid && pop.valid, cnt_r == $past(cnt_r) - QCW'(1),
                "queue count did not drop on pop")

endmodule

`default_nettype wire

@@ hw/rtl/hss_back.sv @@
// ----------------------------------------------------------------------------
// HSV saturation scaler back end
// Pipelined dividers for s and h, saturation gain, six-sector back conversion.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsv_saturation_scaler_defines.svh"

module hss_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hss_pkg::hss_qbus_t   pop,
  input  logic signed [7:0]    sat_level,
  output logic                 out_valid,
  output hss_pkg::hss_pix_out_t out_pixel
);
  import hss_pkg::*;

  logic            dv_vld_r [DIVW];
  hss_work_t       dv_w_r   [DIVW];
  logic [7:0]      dv_rs_r  [DIVW];
  logic [7:0]      dv_rh_r  [DIVW];
  logic [DIVW-1:0] dv_qs_r  [DIVW];
  logic [DIVW-1:0] dv_qh_r  [DIVW];

  for (genvar k = 0; k < DIVW; k++) begin : g_div
    localparam int J = DIVW - 1 - k;
    logic            src_vld;
    hss_work_t       src_w;
    logic [7:0]      src_rs, src_rh;
    logic [DIVW-1:0] src_qs, src_qh;
    logic            bs, bh;
    logic [8:0]      ss, sh;

    if (k == 0) begin : g_first
      assign src_vld = pop.valid;
      assign src_w   = pop.work;
      assign src_rs  = '0;
      assign src_rh  = '0;
      assign src_qs  = '0;
      assign src_qh  = '0;
    end else begin : g_next
      assign src_vld = dv_vld_r[k-1];
      assign src_w   = dv_w_r[k-1];
      assign src_rs  = dv_rs_r[k-1];
      assign src_rh  = dv_rh_r[k-1];
      assign src_qs  = dv_qs_r[k-1];
      assign src_qh  = dv_qh_r[k-1];
    end

    if (J >= FRAC_BITS) begin : g_bh
      assign bh = src_w.n[J-FRAC_BITS];
    end else begin : g_bh0
      assign bh = 1'b0;
    end

    if (J >= FRAC_BITS && J < FRAC_BITS + 8) begin : g_bs
      assign bs = src_w.delta[J-FRAC_BITS];
    end else begin : g_bs0
      assign bs = 1'b0;
    end

    assign ss = div_step(src_rs, src_w.mx, bs);
    assign sh = div_step(src_rh, src_w.delta, bh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else begin
        dv_vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      dv_w_r[k]  <= src_w;
      dv_rs_r[k] <= ss[7:0];
      dv_rh_r[k] <= sh[7:0];
      dv_qs_r[k] <= src_qs | (DIVW'(ss[8]) << J);
      dv_qh_r[k] <= src_qh | (DIVW'(sh[8]) << J);
    end
  end

  hss_work_t        dw;
  logic [ONE_W-1:0] s_q;
  logic [HW-1:0]    h_q;
  logic signed [8:0] gain;
  logic             gain_pos;
  logic [2:0]       sec;
  logic [HW-1:0]    base;

  assign dw       = dv_w_r[DIVW-1];
  assign s_q      = (dw.mx == '0) ? '0 : dv_qs_r[DIVW-1][ONE_W-1:0];
  assign h_q      = (dw.delta == '0) ? '0 : dv_qh_r[DIVW-1][HW-1:0];
  assign gain     = 9'(sat_level) + 9'sd100;
  assign gain_pos = !gain[8] && (gain != 9'sd0);

  always_comb begin
    sec  = '0;
    base = '0;
    for (int k = 1; k < 6; k++) begin
      if (h_q >= (HW'(60 * k) << FRAC_BITS)) begin
        sec  = 3'(k);
        base = HW'(60 * k) << FRAC_BITS;
      end
    end
  end

  // stage 1: gain product, sector split
  logic             b1_vld_r;
  logic [PW-1:0]    b1_p_r;
  logic [2:0]       b1_sec_r;
  logic [TW-1:0]    b1_t_r;
  logic [ONE_W-1:0] b1_v_r;
  logic [7:0]       b1_mx_r;

  always_ff @(posedge clk) begin
    b1_p_r   <= gain_pos ? PW'(s_q) * PW'(gain[7:0]) : '0;
    b1_sec_r <= sec;
    b1_t_r   <= TW'(h_q - base);
    b1_v_r   <= dw.v;
    b1_mx_r  <= dw.mx;
  end

  // stage 2: divide by 100 and by 60 through reciprocals, clamp
  logic [PW+M100W-1:0] prod100;
  logic [ONE_W:0]      s2;
  logic [TW-1:0]       fn;
  logic [TW+M60W-1:0]  prod60;

  assign prod100 = (PW+M100W)'(b1_p_r) * (PW+M100W)'(M100);
  assign s2      = (ONE_W+1)'(prod100 >> K100);
  assign fn      = b1_sec_r[0] ? SIXTY_Q - b1_t_r : b1_t_r;
  assign prod60  = (TW+M60W)'(fn) * (TW+M60W)'(M60);

  logic             b2_vld_r;
  logic [ONE_W-1:0] b2_sc_r, b2_f_r, b2_v_r;
  logic [2:0]       b2_sec_r;
  logic [7:0]       b2_mx_r;

  always_ff @(posedge clk) begin
    b2_sc_r  <= (s2 > {1'b0, ONE_Q}) ? ONE_Q : s2[ONE_W-1:0];
    b2_f_r   <= ONE_W'(prod60 >> K60);
    b2_v_r   <= b1_v_r;
    b2_sec_r <= b1_sec_r;
    b2_mx_r  <= b1_mx_r;
  end

  // stage 3: chroma
  logic [2*ONE_W-1:0] cprod;
  assign cprod = (2*ONE_W)'(b2_v_r) * (2*ONE_W)'(b2_sc_r);

  logic             b3_vld_r, b3_gray_r;
  logic [ONE_W-1:0] b3_c_r, b3_f_r, b3_v_r;
  logic [2:0]       b3_sec_r;
  logic [7:0]       b3_mx_r;

  always_ff @(posedge clk) begin
    b3_c_r    <= ONE_W'(cprod >> FRAC_BITS);
    b3_gray_r <= (b2_sc_r < S_MIN);
    b3_f_r    <= b2_f_r;
    b3_v_r    <= b2_v_r;
    b3_sec_r  <= b2_sec_r;
    b3_mx_r   <= b2_mx_r;
  end

  // stage 4: intermediate component and offset
  logic [2*ONE_W-1:0] xprod;
  assign xprod = (2*ONE_W)'(b3_c_r) * (2*ONE_W)'(b3_f_r);

  logic             b4_vld_r, b4_gray_r;
  logic [ONE_W-1:0] b4_c_r, b4_x_r, b4_m_r;
  logic [2:0]       b4_sec_r;
  logic [7:0]       b4_mx_r;

  always_ff @(posedge clk) begin
    b4_x_r    <= ONE_W'(xprod >> FRAC_BITS);
    b4_m_r    <= b3_v_r - b3_c_r;
    b4_c_r    <= b3_c_r;
    b4_gray_r <= b3_gray_r;
    b4_sec_r  <= b3_sec_r;
    b4_mx_r   <= b3_mx_r;
  end

  // stage 5: sector select, back to channels
  logic [ONE_W-1:0] pr, pg, pb;

  always_comb begin
    case (b4_sec_r)
      3'd0: begin
        pr = b4_c_r; pg = b4_x_r; pb = '0;
      end
      3'd1: begin
        pr = b4_x_r; pg = b4_c_r; pb = '0;
      end
      3'd2: begin
        pr = '0; pg = b4_c_r; pb = b4_x_r;
      end
      3'd3: begin
        pr = '0; pg = b4_x_r; pb = b4_c_r;
      end
      3'd4: begin
        pr = b4_x_r; pg = '0; pb = b4_c_r;
      end
      default: begin
        pr = b4_c_r; pg = '0; pb = b4_x_r;
      end
    endcase
  end

  logic         out_vld_r;
  hss_pix_out_t out_r;

  always_ff @(posedge clk) begin
    if (b4_gray_r) begin
      out_r.out_red   <= b4_mx_r;
      out_r.out_green <= b4_mx_r;
      out_r.out_blue  <= b4_mx_r;
    end else begin
      out_r.out_red   <= to_chan(pr + b4_m_r);
      out_r.out_green <= to_chan(pg + b4_m_r);
      out_r.out_blue  <= to_chan(pb + b4_m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      b3_vld_r  <= 1'b0;
      b4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b1_vld_r  <= dv_vld_r[DIVW-1];
      b2_vld_r  <= b1_vld_r;
      b3_vld_r  <= b2_vld_r;
      b4_vld_r  <= b3_vld_r;
      out_vld_r <= b4_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pixel = out_r;

  `HSS_AST_NEXT(a_gray_equal, b4_vld_r && b4_gray_r,
                out_r.out_red == out_r.out_green && out_r.out_green == out_r.out_blue,
                "gray pixel with unequal channels")

endmodule

`default_nettype wire

@@ hw/rtl/hsv_saturation_scaler.sv @@
// ----------------------------------------------------------------------------
// HSV saturation scaler
// Scales the HSV saturation of RGB pixels by (100 + level) / 100.
// ----------------------------------------------------------------------------
// Input: a pixel transfer happens at a clock edge with start high and busy low.
// Output: each result pixel is on out_pixel for one cycle with out_valid high;
//   the receiver takes it then and cannot hold it off.
// Config: cfg_we writes cfg_wdata (signed percent) into the level register;
//   write it only while no pixel is in flight.
// Pipeline: from input transfer to output transfer a pixel passes two front
//   stages, the queue, NW + FRAC_BITS restoring divider stages for saturation
//   and hue, and five back-conversion stages.
// Throughput: one pixel per cycle while busy is low; results come out in transfer order.
// busy rises only if the front/back queue backs up, which does not happen
//   in steady streaming since the back end drains one entry every cycle.
// Reset: synchronous active low; clears the level to 0 and drops all work.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_saturation_scaler (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  hss_pkg::hss_pix_in_t  in_pixel,
  output logic                  out_valid,
  output hss_pkg::hss_pix_out_t out_pixel,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);
  import hss_pkg::*;

  logic signed [7:0] sat_level_r;
  logic              in_acc;
  hss_qbus_t         push, pop;

  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_level_r <= '0;
    end else if (cfg_we) begin
      sat_level_r <= cfg_wdata;
    end
  end

  hss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_pixel (in_pixel),
    .push     (push)
  );

  hss_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .busy  (busy)
  );

  hss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .sat_level (sat_level_r),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

endmodule

`default_nettype wire

@@ dv/hsv_saturation_scaler_test.sv @@
// ----------------------------------------------------------------------------
// HSV saturation scaler testbench
// Drives RGB pixels through the scaler under several saturation levels and
// compares every output pixel with a fixed-point HSV model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsv_saturation_scaler_test;
  import hss_pkg::*;

  localparam int       FB       = FRAC_BITS;
  localparam longint   ONE      = 64'd1 << FB;
  localparam longint   SMIN     = (ONE * 2) / 1000;
  localparam longint   SIXTY    = 60 * ONE;
  localparam int       LATENCY  = 60;
  localparam longint   MAX_CYC  = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  hss_pix_in_t  in_pixel = '0;
  logic         out_valid;
  hss_pix_out_t out_pixel;
  logic         cfg_we = 1'b0;
  logic [7:0]   cfg_wdata = '0;

  logic [7:0]   level_q = '0;
  hss_pix_out_t pixel_q[$];
  int           errors = 0;
  int           sent = 0;
  int           checked = 0;
  longint       cycles = 0;
  bit           quiet = 1'b0;

  hsv_saturation_scaler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_pixel(out_pixel), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] level_chan(longint q);
    longint x;
    x = (q * 255) >>> FB;
    return (x > 255) ? 8'd255 : x[7:0];
  endfunction

  function automatic hss_pix_out_t scale_pixel(hss_pix_in_t p, logic [7:0] lvl);
    longint r, g, b, mx, mn, dl, v, s, h, n, s2, sec, t, f, c, x, m, pr, pg, pb;
    hss_pix_out_t o;
    r = p.in_red; g = p.in_green; b = p.in_blue;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dl = mx - mn;
    v = (mx * ONE + 254) / 255;
    s = 0; h = 0;
    if (mx != 0) begin
      s = (dl * ONE) / mx;
      if (dl != 0) begin
        if (r == mx) n = (g >= b) ? 60 * (g - b) : 360 * dl - 60 * (b - g);
        else if (g == mx) n = 120 * dl + 60 * (b - r);
        else n = 240 * dl + 60 * (r - g);
        h = (n * ONE) / dl;
      end
    end
    s2 = (s * (100 + longint'($signed(lvl)))) / 100;
    if (s2 < 0) s2 = 0;
    if (s2 > ONE) s2 = ONE;
    if (s2 < SMIN) begin
      o.out_red = level_chan(v); o.out_green = o.out_red; o.out_blue = o.out_red;
      return o;
    end
    sec = h / SIXTY;
    if (sec > 5) sec = 5;
    t = h - sec * SIXTY;
    if (t > SIXTY) t = SIXTY;
    f = sec[0] ? (SIXTY - t) / 60 : t / 60;
    c = (v * s2) >>> FB;
    x = (c * f) >>> FB;
    m = v - c;
    case (sec)
      0: begin pr = c; pg = x; pb = 0; end
      1: begin pr = x; pg = c; pb = 0; end
      2: begin pr = 0; pg = c; pb = x; end
      3: begin pr = 0; pg = x; pb = c; end
      4: begin pr = x; pg = 0; pb = c; end
      default: begin pr = c; pg = 0; pb = x; end
    endcase
    o.out_red = level_chan(pr + m);
    o.out_green = level_chan(pg + m);
    o.out_blue = level_chan(pb + m);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d (pixel %0d)", what, got, want, checked);
  endtask

  always @(posedge clk) begin
    hss_pix_out_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel", out_pixel, 0);
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel.out_red !== want.out_red)
          report_mismatch("red", out_pixel.out_red, want.out_red);
        if (out_pixel.out_green !== want.out_green)
          report_mismatch("green", out_pixel.out_green, want.out_green);
        if (out_pixel.out_blue !== want.out_blue)
          report_mismatch("blue", out_pixel.out_blue, want.out_blue);
      end
      checked++;
    end
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold start high through the transfer; a random low gap may come first
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hss_pix_in_t p;
    p.in_red = r; p.in_green = g; p.in_blue = b;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    start <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_q.push_back(scale_pixel(p, level_q));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_set(logic [7:0] lvl);
    start <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lvl;
    level_q = lvl;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd77, 8'd77, 8'd77);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd10, 8'd100);
    send_pixel(8'd10, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd10, 8'd200);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd170);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        logic [7:0] gv;
        gv = $urandom_range(0, 255);
        send_pixel(gv, gv, ($urandom_range(0, 1)) ? gv : gv ^ 8'd1);
      end else begin
        send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
      end
    end
  endtask

  task automatic test_levels();
    logic [7:0] lv[9] = '{8'sd0, 8'sd100, -8'sd100, 8'sd127, -8'sd128, 8'sd1, -8'sd50,
                         8'sd37, -8'sd1};
    foreach (lv[k]) begin
      drain_and_set(lv[k]);
      test_directed();
      test_random(130);
    end
    drain_and_set($urandom_range(0, 255));
    quiet = 1'b1;
    test_random(250);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_levels();
    start <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    $display("covered %0d pixels over ten saturation levels incl. both range ends", sent);
    $display("checked %0d output pixels, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
